### sv/lspq_pkg.sv
// Shared codes, stream widths and types of the linear-scan priority queue.
`default_nettype none
package lspq_pkg;

  localparam int unsigned ReqWidth     = 2;
  localparam int unsigned InValWidth   = 32;
  localparam int unsigned InPrioWidth  = 16;
  localparam int unsigned OutValWidth  = 32;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned HeldWidth    = 4;
  localparam int unsigned STdataWidth  = 56;
  localparam int unsigned MTdataWidth  = 40;

  localparam logic [ReqWidth-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqWidth-1:0] REQ_PEEK   = 2'd1;
  localparam logic [ReqWidth-1:0] REQ_PULL   = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  typedef struct packed {
    logic vld;
    logic first;
  } cmp_ctrl_t;

endpackage
`default_nettype wire

### sv/lspq_store.sv
// Entry memory: one write port and one registered read port.
`default_nettype none
module lspq_store #(
  parameter int unsigned DEPTH          = 8,
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16,
  localparam int unsigned IdxW          = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [IdxW-1:0]           wr_addr_i,
  input  wire logic [VALUE_WIDTH-1:0]    wr_val_i,
  input  wire logic [PRIORITY_WIDTH-1:0] wr_prio_i,
  input  wire logic                      rd_en_i,
  input  wire logic [IdxW-1:0]           rd_addr_i,
  output logic      [VALUE_WIDTH-1:0]    rd_val_o,
  output logic      [PRIORITY_WIDTH-1:0] rd_prio_o
);

  logic [VALUE_WIDTH+PRIORITY_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH+PRIORITY_WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_val_i, wr_prio_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_val_o  = rd_q[VALUE_WIDTH+PRIORITY_WIDTH-1:PRIORITY_WIDTH];
  assign rd_prio_o = rd_q[PRIORITY_WIDTH-1:0];

endmodule
`default_nettype wire

### sv/lspq_best.sv
// Shared compare unit: tracks the highest-priority entry over a scan.
`default_nettype none
module lspq_best #(
  parameter int unsigned DEPTH          = 8,
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16,
  localparam int unsigned IdxW          = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire lspq_pkg::cmp_ctrl_t       ctrl_i,
  input  wire logic [IdxW-1:0]           idx_i,
  input  wire logic [VALUE_WIDTH-1:0]    val_i,
  input  wire logic [PRIORITY_WIDTH-1:0] prio_i,
  output logic      [IdxW-1:0]           best_idx_o,
  output logic      [VALUE_WIDTH-1:0]    best_val_o
);

  logic [IdxW-1:0]           best_idx_q;
  logic [VALUE_WIDTH-1:0]    best_val_q;
  logic [PRIORITY_WIDTH-1:0] best_prio_q;
  logic                      take;

  // strictly greater keeps the earliest entry on a tie
  assign take = ctrl_i.vld && (ctrl_i.first || ($signed(prio_i) > $signed(best_prio_q)));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= idx_i;
      best_val_q  <= val_i;
      best_prio_q <= prio_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule
`default_nettype wire

### sv/linear_scan_priority_queue.sv
// Top level of the linear-scan priority queue: sequencer, stream ports and result register.
// Usage:
//   Requests enter on s_axis (tdata: req_type, item_value, item_priority); one result per
//   request leaves on m_axis (tdata: result_value, status, entries_held).
//   Insert appends an entry; peek reports the value of the highest-priority entry (earliest
//   wins on a tie); pull reports it and removes it, moving later entries down one place.
//   Insert, an unused code or an empty/full case goes from idle straight to the result state.
//   Peek scans every entry; pull scans, then shifts the entries behind the winner down, a
//   step that writes nothing when the winner is the newest entry. Throughput is set by the
//   single read port of the entry memory, which the scan and the shift both walk one entry
//   a cycle.
//   s_axis_tready is high only while the sequencer is idle; a new request is taken while the
//   previous result still waits in the output register, and its result is held internally
//   until that register frees up.
//   Reset empties the queue and clears the output valid; memory contents are not cleared.
`default_nettype none
module linear_scan_priority_queue #(
  parameter int unsigned DEPTH          = 8,
  parameter int unsigned VALUE_WIDTH    = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [1:0] req_type, [33:2] item_value, [49:34] item_priority, [55:50] zero
  input  wire logic [lspq_pkg::STdataWidth-1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [31:0] result_value, [33:32] status, [37:34] entries_held, [39:38] zero
  output logic      [lspq_pkg::MTdataWidth-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lspq_pkg::state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic            pull_q, pull_d;
  logic            rdv_q;
  logic [IdxW-1:0] rdi_q;

  logic [lspq_pkg::OutValWidth-1:0] res_val_q, res_val_d;
  logic [lspq_pkg::StatusWidth-1:0] res_st_q, res_st_d;

  logic                             m_vld_q, m_vld_d;
  logic [lspq_pkg::MTdataWidth-1:0] m_data_q, m_data_d;

  logic                             s_fire;
  logic [lspq_pkg::ReqWidth-1:0]    req;
  logic [63:0]                      in_val64;
  logic [31:0]                      in_prio32;
  logic                             rd_en;
  logic                             wr_en;
  logic [IdxW-1:0]                  wr_addr;
  logic [VALUE_WIDTH-1:0]           wr_val;
  logic [PRIORITY_WIDTH-1:0]        wr_prio;
  logic [VALUE_WIDTH-1:0]           rd_val;
  logic [PRIORITY_WIDTH-1:0]        rd_prio;
  logic [IdxW-1:0]                  best_idx;
  logic [VALUE_WIDTH-1:0]           best_val;
  logic [63:0]                      best_val64;
  logic                             walk_done;
  lspq_pkg::cmp_ctrl_t              cmp_ctrl;

  assign s_axis_tready = (state_q == lspq_pkg::S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign req           = s_axis_tdata[1:0];
  assign in_val64      = {32'b0, s_axis_tdata[33:2]};
  assign in_prio32     = {16'b0, s_axis_tdata[49:34]};
  assign best_val64    = 64'(best_val);

  assign rd_en = ((state_q == lspq_pkg::S_SCAN) || (state_q == lspq_pkg::S_SHIFT))
                 && (iss_q < cnt_q);
  assign walk_done = (iss_q == cnt_q) && !rdv_q;

  assign cmp_ctrl.vld   = rdv_q && (state_q == lspq_pkg::S_SCAN);
  assign cmp_ctrl.first = (rdi_q == '0);

  lspq_store #(
    .DEPTH          (DEPTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_val_i  (wr_val),
    .wr_prio_i (wr_prio),
    .rd_en_i   (rd_en),
    .rd_addr_i (iss_q[IdxW-1:0]),
    .rd_val_o  (rd_val),
    .rd_prio_o (rd_prio)
  );

  lspq_best #(
    .DEPTH          (DEPTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_best (
    .clk_i      (clk_i),
    .ctrl_i     (cmp_ctrl),
    .idx_i      (rdi_q),
    .val_i      (rd_val),
    .prio_i     (rd_prio),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    pull_d    = pull_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    m_vld_d   = m_vld_q && !m_axis_tready;
    m_data_d  = m_data_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[IdxW-1:0];
    wr_val    = in_val64[VALUE_WIDTH-1:0];
    wr_prio   = in_prio32[PRIORITY_WIDTH-1:0];

    if (rd_en) begin
      iss_d = iss_q + CntW'(1);
    end

    unique case (state_q)
      lspq_pkg::S_IDLE: begin
        if (s_fire) begin
          res_val_d = '0;
          res_st_d  = lspq_pkg::ST_OK;
          iss_d     = '0;
          pull_d    = (req == lspq_pkg::REQ_PULL);
          state_d   = lspq_pkg::S_RESP;
          unique case (req) inside
            lspq_pkg::REQ_INSERT: begin
              if (cnt_q == CntW'(DEPTH)) begin
                res_st_d = lspq_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end
            end
            lspq_pkg::REQ_PEEK, lspq_pkg::REQ_PULL: begin
              if (cnt_q == '0) begin
                res_st_d = lspq_pkg::ST_EMPTY;
              end else begin
                state_d = lspq_pkg::S_SCAN;
              end
            end
            default: begin
              res_st_d = lspq_pkg::ST_OK;
            end
          endcase
        end
      end
      lspq_pkg::S_SCAN: begin
        if (walk_done) begin
          res_val_d = best_val64[lspq_pkg::OutValWidth-1:0];
          if (pull_q) begin
            iss_d   = CntW'(best_idx) + CntW'(1);
            state_d = lspq_pkg::S_SHIFT;
          end else begin
            state_d = lspq_pkg::S_RESP;
          end
        end
      end
      lspq_pkg::S_SHIFT: begin
        // move each later entry down one place
        if (rdv_q) begin
          wr_en   = 1'b1;
          wr_addr = rdi_q - IdxW'(1);
          wr_val  = rd_val;
          wr_prio = rd_prio;
        end
        if (walk_done) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = lspq_pkg::S_RESP;
        end
      end
      lspq_pkg::S_RESP: begin
        if (!m_vld_q || m_axis_tready) begin
          m_vld_d  = 1'b1;
          m_data_d = {2'b0, lspq_pkg::HeldWidth'(cnt_q), res_st_q, res_val_q};
          state_d  = lspq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lspq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspq_pkg::S_IDLE;
      cnt_q   <= '0;
      iss_q   <= '0;
      pull_q  <= 1'b0;
      rdv_q   <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pull_q  <= pull_d;
      rdv_q   <= rd_en;
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdi_q     <= iss_q[IdxW-1:0];
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire
